FILE: hdl/pol_pkg.sv
// pol_pkg: shared types and constants for the positional ordered list
// command and status codes, cell operations and the cell control bundle
// no dependencies
package pol_pkg;

    localparam int VAL_W        = 32;
    localparam int CAP_MAX      = 64;
    localparam int CAPACITY_DEF = 16;
    localparam int IDX_W        = $clog2(CAP_MAX);

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_AT    = 3'd5,
        CMD_RD_FWD    = 3'd6,
        CMD_RD_BWD    = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_INVALID = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_INSERT = 3'd1,
        CELL_DELETE = 3'd2,
        CELL_ROT_L  = 3'd3,
        CELL_ROT_R  = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [IDX_W-1:0]   idx;
    } cell_ctrl_t;

endpackage

FILE: hdl/pol_cell.sv
// pol_cell: one storage cell of the list chain
// holds one value and takes the inserted value or its neighbor's value on insert, delete or rotate
// depends on pol_pkg
module pol_cell
    import pol_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic             aclk,
    input  cell_ctrl_t       ctrl,
    input  logic [VAL_W-1:0] ins_value,
    input  logic [VAL_W-1:0] left_q,
    input  logic [VAL_W-1:0] right_q,
    output logic [VAL_W-1:0] q,
    output logic [VAL_W-1:0] tap
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        unique case (ctrl.op)
            CELL_INSERT: begin
                if (MY_IDX == ctrl.idx) begin
                    value_next = ins_value;
                end else if (MY_IDX > ctrl.idx) begin
                    value_next = left_q;
                end
            end
            CELL_DELETE: begin
                if (MY_IDX >= ctrl.idx) begin
                    value_next = right_q;
                end
            end
            CELL_ROT_L: value_next = right_q;
            CELL_ROT_R: value_next = left_q;
            default:    value_next = value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    // value leaving the list on a delete at this cell
    assign tap = (ctrl.op == CELL_DELETE && MY_IDX == ctrl.idx) ? value_reg : '0;
    assign q   = value_reg;

endmodule

FILE: hdl/positional_ordered_list_top.sv
// positional_ordered_list_top: bounded ordered list of signed values in a ring of cells
// edits shift the cells together, reads rotate the ring one step per cycle while no step stalls
// depends on pol_pkg and pol_cell
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------
//  s_      | in        | s_valid / s_ready  | s_cmd, s_value, s_position
//  m_      | out       | m_valid / m_ready  | m_item_value, m_status, m_last
//
//  an edit (insert or delete) or a read of an empty list loads its result at its transfer
//  a read of a non-empty list holds s_ready low while the ring takes CAPACITY steps,
//  one ring step per cycle while no step stalls, so the ring turns once;
//  count results come out on the way and a step stalls while its result waits for m_ready
//  s_ready is high only while no read is in progress and the output register is free
//  or being emptied in the same cycle
//  aresetn (synchronous, active low) empties the list; stored values are not cleared
module positional_ordered_list_top
    import pol_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [2:0]              s_cmd,
    input  logic signed [VAL_W-1:0] s_value,
    input  logic [7:0]              s_position,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VAL_W-1:0] m_item_value,
    output logic [1:0]              m_status,
    output logic                    m_last
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int STEP_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(CAPACITY);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CAPACITY - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    // control state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               fwd_reg, fwd_next;
    logic               m_valid_reg, m_valid_next;

    // output payload
    logic [VAL_W-1:0]   m_value_reg;
    status_t            m_status_reg;
    logic               m_last_reg;

    // output load request
    logic               ld;
    logic [VAL_W-1:0]   ld_value;
    status_t            ld_status;
    logic               ld_last;

    // cell ring
    cell_ctrl_t         ctrl;
    logic [VAL_W-1:0]   cell_q   [CAPACITY];
    logic [VAL_W-1:0]   cell_tap [CAPACITY];
    logic [VAL_W-1:0]   pick;

    logic               out_free;
    logic               accept;
    logic [8:0]         pos_ext;
    logic [8:0]         cnt_ext;
    logic               is_full;
    logic               is_empty;
    logic               emit_win;
    logic               emit_last;
    logic               advance;
    logic [CNT_W-1:0]   step_ext;

    // ---------------------------------------------------------------------
    // ring of cells: each cell sees its two neighbors, ends wrap around
    // ---------------------------------------------------------------------
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        pol_cell #(
            .IDX (g)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .ins_value (s_value),
            .left_q    (cell_q[(g + CAPACITY - 1) % CAPACITY]),
            .right_q   (cell_q[(g + 1) % CAPACITY]),
            .q         (cell_q[g]),
            .tap       (cell_tap[g])
        );
    end

    // only the cell being deleted drives a nonzero tap
    always_comb begin
        pick = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            pick = pick | cell_tap[i];
        end
    end

    // ---------------------------------------------------------------------
    // handshake and command decode
    // ---------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    assign pos_ext  = {1'b0, s_position};
    assign cnt_ext  = 9'(count_reg);
    assign is_full  = (count_reg == CNT_FULL);
    assign is_empty = (count_reg == '0);

    // read window: forward emits while cell 0 holds a list entry, backward
    // emits once the tail has been rotated into the last cell
    assign step_ext  = CNT_W'(step_reg);
    assign emit_win  = fwd_reg ? (step_ext < count_reg)
                               : (step_ext >= (CNT_FULL - count_reg));
    assign emit_last = fwd_reg ? (step_ext == (count_reg - CNT_W'(1)))
                               : (step_reg == STEP_LAST);
    assign advance   = !emit_win || out_free;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        step_next  = step_reg;
        fwd_next   = fwd_reg;
        ctrl.op    = CELL_HOLD;
        ctrl.idx   = '0;
        ld         = 1'b0;
        ld_value   = s_value;
        ld_status  = STAT_OK;
        ld_last    = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ld = 1'b1;
                    unique case (cmd_t'(s_cmd))
                        CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
                            // offered value is echoed whatever the outcome
                            ld_value = s_value;
                            if (is_full) begin
                                ld_status = STAT_FULL;
                            end else if (cmd_t'(s_cmd) == CMD_INS_AT &&
                                         (pos_ext == 9'd0 || pos_ext > cnt_ext + 9'd1)) begin
                                ld_status = STAT_INVALID;
                            end else begin
                                ctrl.op    = CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                                priority case (cmd_t'(s_cmd))
                                    CMD_INS_FRONT: ctrl.idx = '0;
                                    CMD_INS_BACK:  ctrl.idx = IDX_W'(count_reg);
                                    default:       ctrl.idx = IDX_W'(s_position - 8'd1);
                                endcase
                            end
                        end
                        CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
                            ld_value = '0;
                            if (is_empty) begin
                                ld_status = STAT_EMPTY;
                            end else if (cmd_t'(s_cmd) == CMD_DEL_AT &&
                                         (pos_ext == 9'd0 || pos_ext > cnt_ext)) begin
                                ld_status = STAT_INVALID;
                            end else begin
                                ctrl.op    = CELL_DELETE;
                                count_next = count_reg - CNT_W'(1);
                                ld_value   = pick;
                                priority case (cmd_t'(s_cmd))
                                    CMD_DEL_FRONT: ctrl.idx = '0;
                                    CMD_DEL_BACK:  ctrl.idx = IDX_W'(count_reg - CNT_W'(1));
                                    default:       ctrl.idx = IDX_W'(s_position - 8'd1);
                                endcase
                            end
                        end
                        CMD_RD_FWD, CMD_RD_BWD: begin
                            ld_value = '0;
                            if (is_empty) begin
                                ld_status = STAT_EMPTY;
                            end else begin
                                // results come from the rotation steps instead
                                ld         = 1'b0;
                                state_next = ST_READ;
                                step_next  = '0;
                                fwd_next   = (cmd_t'(s_cmd) == CMD_RD_FWD);
                            end
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (advance) begin
                    ctrl.op   = fwd_reg ? CELL_ROT_L : CELL_ROT_R;
                    ld        = emit_win;
                    ld_value  = fwd_reg ? cell_q[0] : cell_q[CAPACITY-1];
                    ld_status = STAT_OK;
                    ld_last   = emit_last;
                    // a full turn of the ring leaves the list where it was
                    if (step_reg == STEP_LAST) begin
                        state_next = ST_IDLE;
                        step_next  = '0;
                    end else begin
                        step_next = step_reg + STEP_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = ld ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // ---------------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            step_reg    <= '0;
            fwd_reg     <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
            fwd_reg     <= fwd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            m_value_reg  <= ld_value;
            m_status_reg <= ld_status;
            m_last_reg   <= ld_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_item_value = m_value_reg;
    assign m_status     = m_status_reg;
    assign m_last       = m_last_reg;

endmodule

FILE: hdl/pol_checker.sv
// pol_checker: port-level assertions for positional_ordered_list_top
// bound to the top level at the end of this file
// depends on pol_pkg
module pol_checker
    import pol_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic [2:0]              s_cmd,
    input logic signed [VAL_W-1:0] s_value,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [VAL_W-1:0] m_item_value,
    input logic [1:0]              m_status,
    input logic                    m_last
);

    logic edit_xfer;
    logic ins_xfer;
    logic del_xfer;

    assign ins_xfer  = s_valid && s_ready &&
                       (s_cmd == CMD_INS_FRONT || s_cmd == CMD_INS_BACK ||
                        s_cmd == CMD_INS_AT);
    assign del_xfer  = s_valid && s_ready &&
                       (s_cmd == CMD_DEL_FRONT || s_cmd == CMD_DEL_BACK ||
                        s_cmd == CMD_DEL_AT);
    assign edit_xfer = ins_xfer || del_xfer;

    // no result right after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an edit gives its single final result in the next cycle
    a_edit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        edit_xfer |=> m_valid && m_last)
        else $error("edit result missing or not marked last");

    // an insert echoes the offered value and never reports empty
    a_ins_echo: assert property (@(posedge aclk) disable iff (!aresetn)
        ins_xfer |=> m_item_value == $past(s_value) && m_status != STAT_EMPTY)
        else $error("insert result does not echo the offered value");

    // a read in progress blocks new commands
    a_read_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("command taken while a read is still streaming");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item_value) &&
                                $stable(m_status) && $stable(m_last))
        else $error("stalled result changed");

endmodule

bind positional_ordered_list_top pol_checker u_pol_checker (.*);
